@@ design/hobfp_pkg.sv @@
// ----------------------------------------------------------------------------
// hobfp_pkg
// Shared types, character codes and the hex digit decoder of the
// hex-or-binary frame parser.
// ----------------------------------------------------------------------------
package hobfp_pkg;

    localparam int FRAME_BYTES_DEF = 128;

    localparam logic [7:0] CH_BINARY = 8'h7D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic       binary_mode;
        logic [7:0] expected_length;
        logic [7:0] byte_count;
        logic [3:0] pending_nibble;
        logic       nibble_held;
    } t_state;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       frame_end;
        logic       frame_abort;
        logic       overflow;
    } t_result;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } t_hex;

    function automatic t_hex hex_value(input logic [7:0] ch);
        t_hex h;
        h = '0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            h.ok  = 1'b1;
            h.val = 4'(ch - 8'h30);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            h.ok  = 1'b1;
            h.val = 4'(ch - 8'h41 + 8'd10);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            h.ok  = 1'b1;
            h.val = 4'(ch - 8'h61 + 8'd10);
        end
        return h;
    endfunction

endpackage

@@ design/hex_or_binary_frame_parser.sv @@
// ----------------------------------------------------------------------------
// hex_or_binary_frame_parser
// Streams frame bytes from received characters: hex pairs in text mode,
// length-prefixed raw bytes after a binary switch character.
// ----------------------------------------------------------------------------
// path: byte into the input register, then result into the output register
// throughput: one byte per cycle unless the output stalls, set by the single
// input and result registers; a no-result byte still passes the input register
// reset: synchronous, active low; clears mode, length, count and half pair
// ----------------------------------------------------------------------------
module hex_or_binary_frame_parser #(
    parameter int FRAME_BYTES = hobfp_pkg::FRAME_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_frame_end,
    output logic       o_frame_abort,
    output logic       o_overflow
);
    import hobfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    logic       r_out_valid;
    t_result    r_out;

    t_state     n_state;
    t_result    n_out;
    logic       w_has_result;
    logic       w_advance;

    hobfp_decode #(
        .FRAME_BYTES(FRAME_BYTES)
    ) u_decode (
        .i_state     (r_state),
        .i_rx_byte   (r_in_byte),
        .o_next      (n_state),
        .o_result    (n_out),
        .o_has_result(w_has_result)
    );

    assign w_advance  = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_state     <= n_state;
                r_out_valid <= w_has_result;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_advance && w_has_result) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out.out_byte;
    assign o_byte_valid  = r_out.byte_valid;
    assign o_frame_end   = r_out.frame_end;
    assign o_frame_abort = r_out.frame_abort;
    assign o_overflow    = r_out.overflow;

    a_abort_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_abort) |->
            (!o_byte_valid && !o_frame_end && !o_overflow && o_out_byte == 8'd0))
        else $error("abort result carries other fields");

    a_overflow_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow) |-> o_byte_valid)
        else $error("overflow without a frame byte");

    a_length_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.expected_length != 8'd0) |->
            (r_state.binary_mode && r_state.byte_count < r_state.expected_length))
        else $error("binary length or count out of step");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_stall) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("held input byte lost while stalled");

endmodule

@@ design/hobfp_decode.sv @@
// ----------------------------------------------------------------------------
// hobfp_decode
// Next-state and result logic for one received byte, text or binary mode.
// ----------------------------------------------------------------------------
module hobfp_decode #(
    parameter int FRAME_BYTES = hobfp_pkg::FRAME_BYTES_DEF
) (
    input  hobfp_pkg::t_state  i_state,
    input  logic [7:0]         i_rx_byte,
    output hobfp_pkg::t_state  o_next,
    output hobfp_pkg::t_result o_result,
    output logic               o_has_result
);
    import hobfp_pkg::*;

    localparam logic [7:0] CAPACITY = 8'(FRAME_BYTES);

    t_hex       w_hex;
    logic       w_ovf;
    logic [7:0] w_cnt_inc;

    assign w_hex     = hex_value(i_rx_byte);
    assign w_ovf     = (i_state.byte_count >= CAPACITY);
    assign w_cnt_inc = (i_state.byte_count == COUNT_MAX) ? i_state.byte_count
                                                         : i_state.byte_count + 8'd1;

    always_comb begin
        o_next       = i_state;
        o_result     = '0;
        o_has_result = 1'b0;
        if (i_state.binary_mode) begin
            if (i_state.expected_length == 8'd0) begin
                if (i_rx_byte != 8'd0) begin
                    o_next.expected_length = i_rx_byte;
                    o_next.byte_count      = 8'd0;
                    if (i_state.byte_count != 8'd0) begin
                        o_has_result         = 1'b1;
                        o_result.frame_abort = 1'b1;
                    end
                end
            end else begin
                o_has_result        = 1'b1;
                o_result.out_byte   = i_rx_byte;
                o_result.byte_valid = 1'b1;
                o_result.overflow   = w_ovf;
                o_result.frame_end  = (w_cnt_inc == i_state.expected_length);
                o_next.byte_count   = w_cnt_inc;
                if (w_cnt_inc == i_state.expected_length) begin
                    o_next.byte_count      = 8'd0;
                    o_next.binary_mode     = 1'b0;
                    o_next.expected_length = 8'd0;
                end
            end
        end else begin
            priority if (i_rx_byte == CH_SPACE) begin
                o_next = i_state;
            end else if (i_rx_byte == CH_BINARY) begin
                o_next.binary_mode = 1'b1;
            end else if (i_rx_byte == CH_CR) begin
                o_has_result          = 1'b1;
                o_result.frame_end    = 1'b1;
                o_next.nibble_held    = 1'b0;
                o_next.pending_nibble = 4'd0;
                o_next.byte_count     = 8'd0;
            end else if (w_hex.ok) begin
                if (!i_state.nibble_held) begin
                    o_next.pending_nibble = w_hex.val;
                    o_next.nibble_held    = 1'b1;
                end else begin
                    o_has_result          = 1'b1;
                    o_result.out_byte     = {i_state.pending_nibble, w_hex.val};
                    o_result.byte_valid   = 1'b1;
                    o_result.overflow     = w_ovf;
                    o_next.byte_count     = w_cnt_inc;
                    o_next.nibble_held    = 1'b0;
                    o_next.pending_nibble = 4'd0;
                end
            end else begin
                o_next = i_state;
            end
        end
    end

endmodule

@@ tb/sv/tb_hex_or_binary_frame_parser.sv @@
// ----------------------------------------------------------------------------
// tb_hex_or_binary_frame_parser
// Drives received characters into the frame parser through the valid/stall
// input channel and checks every result transfer field by field against a
// cycle-free predictor of the text and binary framing rules. A short
// directed table comes first, then random text frames, binary frames and
// noise, with random idle cycles on the input side and random stalls on
// the output side.
// ----------------------------------------------------------------------------
module tb_hex_or_binary_frame_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import hobfp_pkg::*;

    localparam int FRAME_BYTES = FRAME_BYTES_DEF;
    localparam int ITEM_TARGET = 900;
    localparam int DIR_ROWS    = 25;

    localparam logic [7:0] CH_DIGIT0  = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_DIGIT9  = 8'h39;

    typedef struct packed {
        logic [7:0] ch;
        logic       fixed;
        t_result    want;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    logic [7:0] i_rx_byte = 8'h00;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_valid;
    logic       o_frame_end;
    logic       o_frame_abort;
    logic       o_overflow;

    t_state     parser_st;
    t_result    pending_frames[$];
    t_result    want_res;
    t_dir_row   dir_rows [DIR_ROWS];
    int         err_count = 0;
    int         items_sent = 0;
    int         stall_left = 0;
    bit         quiet = 1'b0;

    hex_or_binary_frame_parser #(
        .FRAME_BYTES(FRAME_BYTES)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_rx_byte    (i_rx_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_frame_end  (o_frame_end),
        .o_frame_abort(o_frame_abort),
        .o_overflow   (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit decode_frame_byte(input logic [7:0] c, output t_result r);
        logic [4:0] digit;
        r = '0;
        if (parser_st.binary_mode) begin
            if (parser_st.expected_length == 8'h00) begin
                if (c == 8'h00)
                    return 1'b0;
                parser_st.expected_length = c;
                if (parser_st.byte_count != 8'h00) begin
                    parser_st.byte_count = 8'h00;
                    r.frame_abort = 1'b1;
                    return 1'b1;
                end
                return 1'b0;
            end
            r.overflow = (parser_st.byte_count >= FRAME_BYTES);
            if (parser_st.byte_count != COUNT_MAX)
                parser_st.byte_count++;
            r.out_byte   = c;
            r.byte_valid = 1'b1;
            r.frame_end  = (parser_st.byte_count == parser_st.expected_length);
            if (r.frame_end) begin
                parser_st.byte_count      = 8'h00;
                parser_st.binary_mode     = 1'b0;
                parser_st.expected_length = 8'h00;
            end
            return 1'b1;
        end
        if (c == CH_SPACE)
            return 1'b0;
        if (c == CH_BINARY) begin
            parser_st.binary_mode = 1'b1;
            return 1'b0;
        end
        if (c == CH_CR) begin
            r.frame_end              = 1'b1;
            parser_st.nibble_held    = 1'b0;
            parser_st.pending_nibble = 4'h0;
            parser_st.byte_count     = 8'h00;
            return 1'b1;
        end
        digit = 5'd16;
        if (c >= CH_DIGIT0 && c <= CH_DIGIT9)
            digit = 5'(c - CH_DIGIT0);
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            digit = 5'(c - CH_UPPER_A + 8'd10);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            digit = 5'(c - CH_LOWER_A + 8'd10);
        if (digit[4])
            return 1'b0;
        if (!parser_st.nibble_held) begin
            parser_st.pending_nibble = digit[3:0];
            parser_st.nibble_held    = 1'b1;
            return 1'b0;
        end
        r.out_byte   = {parser_st.pending_nibble, digit[3:0]};
        r.byte_valid = 1'b1;
        r.overflow   = (parser_st.byte_count >= FRAME_BYTES);
        if (parser_st.byte_count != COUNT_MAX)
            parser_st.byte_count++;
        parser_st.nibble_held    = 1'b0;
        parser_st.pending_nibble = 4'h0;
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return CH_DIGIT0 + 8'(v);
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] text_noise();
        logic [7:0] c;
        c = 8'($urandom);
        if (c == CH_CR || c == CH_BINARY)
            c = CH_SPACE;
        return c;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_char(input logic [7:0] c, input bit fixed = 1'b0,
                             input t_result fixed_res = '0);
        t_result r;
        t_state  prev_st;
        bit      has;
        int      gap;
        i_in_valid <= 1'b1;
        i_rx_byte  <= c;
        do @(posedge i_clk); while (o_in_stall);
        prev_st = parser_st;
        has = decode_frame_byte(c, r);
        if (has)
            pending_frames.push_back(fixed ? fixed_res : r);
        if (has || parser_st != prev_st)
            items_sent++;
        if ($urandom_range(0, 39) == 0)
            quiet = !quiet;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic binary_frame(input bit allow_long);
        int len;
        send_char(CH_BINARY);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_char(8'h00);
        if (allow_long && $urandom_range(0, 7) == 0)
            len = $urandom_range(FRAME_BYTES + 1, 255);
        else
            len = $urandom_range(1, 16);
        send_char(8'(len));
        repeat (len) send_char(8'($urandom));
    endtask

    task automatic random_frame();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            repeat ($urandom_range(0, 12)) begin
                if ($urandom_range(0, 5) == 0)
                    send_char(text_noise());
                send_char(hex_char(4'($urandom)));
                if ($urandom_range(0, 15) != 0)
                    send_char(hex_char(4'($urandom)));
            end
            if ($urandom_range(0, 7) != 0)
                send_char(CH_CR);
        end else if (kind < 9) begin
            binary_frame(1'b1);
        end else begin
            repeat ($urandom_range(1, 6)) send_char(8'($urandom));
        end
    endtask

    // output side draws a random stall length after each transfer
    always @(posedge i_clk) begin
        if (!i_rst_n)
            stall_left = 0;
        else if (o_out_valid && !i_out_stall)
            stall_left = quiet ? 0 : $urandom_range(0, 10);
        else if (stall_left != 0)
            stall_left--;
        i_out_stall <= (stall_left != 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_frames.size() == 0) begin
                err_count++;
                $display("%0t: unexpected transfer, expected none actual %02h %b%b%b%b",
                         $time, o_out_byte, o_byte_valid, o_frame_end, o_frame_abort,
                         o_overflow);
            end else begin
                want_res = pending_frames.pop_front();
                check_field("out_byte", 32'(want_res.out_byte), 32'(o_out_byte));
                check_field("byte_valid", 32'(want_res.byte_valid), 32'(o_byte_valid));
                check_field("frame_end", 32'(want_res.frame_end), 32'(o_frame_end));
                check_field("frame_abort", 32'(want_res.frame_abort),
                            32'(o_frame_abort));
                check_field("overflow", 32'(want_res.overflow), 32'(o_overflow));
            end
        end
    end

    initial begin
        dir_rows = '{
            '{CH_CR,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
            '{"0",       1'b0, '0},
            '{"0",       1'b1, '{8'h00, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{"F",       1'b0, '0},
            '{"f",       1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{"a",       1'b0, '0},
            '{CH_SPACE,  1'b0, '0},
            '{"G",       1'b0, '0},
            '{"9",       1'b1, '{8'hA9, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{"A",       1'b0, '0},
            '{CH_BINARY, 1'b0, '0},
            '{8'h00,     1'b0, '0},
            '{8'h02,     1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}},
            '{8'hFF,     1'b0, '0},
            '{8'h00,     1'b1, '{8'h00, 1'b1, 1'b1, 1'b0, 1'b0}},
            '{"B",       1'b1, '{8'hAB, 1'b1, 1'b0, 1'b0, 1'b0}},
            '{CH_CR,     1'b1, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0}},
            '{CH_BINARY, 1'b0, '0},
            '{8'h01,     1'b0, '0},
            '{CH_BINARY, 1'b0, '0},
            '{8'h80,     1'b0, '0},
            '{"7",       1'b0, '0},
            '{"7",       1'b0, '0},
            '{CH_BINARY, 1'b0, '0},
            '{8'h04,     1'b1, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0}}
        };
        parser_st = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_char(dir_rows[i].ch, dir_rows[i].fixed, dir_rows[i].want);
        // finish the open binary frame left by the table
        repeat (4) send_char(8'($urandom));

        // text frame long enough to saturate the count, cut off by a length byte
        repeat ($urandom_range(256, 260)) begin
            send_char(hex_char(4'($urandom)));
            send_char(hex_char(4'($urandom)));
        end
        binary_frame(1'b0);

        while (items_sent < ITEM_TARGET)
            random_frame();
        i_in_valid <= 1'b0;

        while (pending_frames.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
design/hobfp_pkg.sv
design/hobfp_decode.sv
design/hex_or_binary_frame_parser.sv
tb/sv/tb_hex_or_binary_frame_parser.sv
